FILE: sv/gqr_pkg.sv
// ----------------------------------------------------------------------------
// gqr_pkg
// Shared widths, codes and status types of the Givens QR core.
// ----------------------------------------------------------------------------
package gqr_pkg;

  localparam int IN_W  = 32;
  localparam int OUT_W = 32;
  localparam int THR_W = 31;
  localparam int IDX_W = 2;

  localparam logic [THR_W-1:0] THR_RESET = 31'd17;

  typedef enum logic {
    MAT_R = 1'b0,
    MAT_Q = 1'b1
  } mat_sel_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: sv/gqr_row_cell.sv
// ----------------------------------------------------------------------------
// gqr_row_cell
// One matrix row held as a circular shift line; the head element is exposed.
// ----------------------------------------------------------------------------
module gqr_row_cell #(
  parameter int LEN = 8,
  parameter int DW  = 32
) (
  input  logic                 clk,
  input  logic                 shift,
  input  logic signed [DW-1:0] din,
  output logic signed [DW-1:0] head
);

  logic signed [DW-1:0] elem [LEN];

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int e = 0; e < LEN - 1; e++) begin
        elem[e] <= elem[e+1];
      end
      elem[LEN-1] <= din;
    end
  end

  assign head = elem[0];

endmodule

FILE: sv/gqr_sqrt.sv
// ----------------------------------------------------------------------------
// gqr_sqrt
// Root of a sum of squares: shift-add squaring, then one root bit a cycle.
// ----------------------------------------------------------------------------
module gqr_sqrt import gqr_pkg::*; #(
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  output unit_stat_t           stat,
  output logic        [DW-1:0] root
);

  localparam int CW = $clog2(DW + 1);
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SQUARE,
    SQ_ROOT
  } state_t;

  state_t          state;
  logic            done;
  logic [CW-1:0]   cnt;
  logic [DW-1:0]   ma_r;
  logic [DW-1:0]   mb_r;
  logic [2*DW-1:0] ms_a;
  logic [2*DW-1:0] ms_b;
  logic [2*DW-1:0] acc;
  logic [2*DW-1:0] acc_next;
  logic [2*DW-1:0] nreg;
  logic [DW:0]     rem;
  logic [DW-1:0]   root_r;
  logic [DW-1:0]   mag_a;
  logic [DW-1:0]   mag_b;
  logic [DW+2:0]   rem_sh;
  logic [DW+2:0]   trial;

  always_comb begin
    mag_a    = a[DW-1] ? DW'(-a) : DW'(a);
    mag_b    = b[DW-1] ? DW'(-b) : DW'(b);
    acc_next = acc + (ma_r[0] ? ms_a : '0) + (mb_r[0] ? ms_b : '0);
    rem_sh   = {rem, nreg[2*DW-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        SQ_IDLE: begin
          if (start) begin
            ma_r  <= mag_a;
            mb_r  <= mag_b;
            ms_a  <= {{DW{1'b0}}, mag_a};
            ms_b  <= {{DW{1'b0}}, mag_b};
            acc   <= '0;
            cnt   <= '0;
            state <= SQ_SQUARE;
          end
        end
        SQ_SQUARE: begin
          acc  <= acc_next;
          ma_r <= ma_r >> 1;
          mb_r <= mb_r >> 1;
          ms_a <= ms_a << 1;
          ms_b <= ms_b << 1;
          if (cnt == CW'(DW - 1)) begin
            nreg   <= acc_next;
            rem    <= '0;
            root_r <= '0;
            cnt    <= '0;
            state  <= SQ_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        SQ_ROOT: begin
          nreg <= nreg << 2;
          if (rem_sh >= trial) begin
            rem    <= (DW+1)'(rem_sh - trial);
            root_r <= {root_r[DW-2:0], 1'b1};
          end else begin
            rem    <= (DW+1)'(rem_sh);
            root_r <= {root_r[DW-2:0], 1'b0};
          end
          if (cnt == CW'(DW - 1)) begin
            state <= SQ_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= SQ_IDLE;
      endcase
    end
  end

  assign root      = (root_r > MAXV) ? MAXV : root_r;
  assign stat.busy = (state != SQ_IDLE);
  assign stat.done = done;

endmodule

FILE: sv/gqr_div.sv
// ----------------------------------------------------------------------------
// gqr_div
// Fixed-point fraction divide, one quotient bit a cycle, round half away.
// ----------------------------------------------------------------------------
module gqr_div import gqr_pkg::*; #(
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] num,
  input  logic        [DW-1:0] den,
  output unit_stat_t           stat,
  output logic signed [DW-1:0] quo
);

  localparam int FB = DW - 8;
  localparam int CW = $clog2(FB + 1);
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};

  typedef enum logic {
    DV_IDLE,
    DV_RUN
  } state_t;

  state_t        state;
  logic          done;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [FB+1:0] q;
  logic [DW-1:0] mag;
  logic [DW:0]   rem_sh;
  logic [FB+2:0] q_inc;
  logic [DW-1:0] q_rnd;
  logic [DW-1:0] q_sat;

  always_comb begin
    mag    = num[DW-1] ? DW'(-num) : DW'(num);
    rem_sh = {rem[DW-1:0], 1'b0};
    q_inc  = (FB+3)'(q) + 1'b1;
    q_rnd  = DW'(q_inc[FB+2:1]);
    q_sat  = (q_rnd > MAXV) ? MAXV : q_rnd;
    quo    = neg ? -$signed(q_sat) : $signed(q_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        DV_IDLE: begin
          if (start) begin
            neg <= num[DW-1];
            cnt <= '0;
            if (mag >= den) begin
              rem <= (DW+1)'(mag - den);
              q   <= (FB+2)'(1);
            end else begin
              rem <= (DW+1)'(mag);
              q   <= '0;
            end
            state <= DV_RUN;
          end
        end
        DV_RUN: begin
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            q   <= {q[FB:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q   <= {q[FB:0], 1'b0};
          end
          if (cnt == CW'(FB)) begin
            state <= DV_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != DV_IDLE);
  assign stat.done = done;

endmodule

FILE: sv/gqr_rotate.sv
// ----------------------------------------------------------------------------
// gqr_rotate
// Plane rotation of one element pair: registered products, then round/clamp.
// ----------------------------------------------------------------------------
module gqr_rotate #(
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic signed [DW-1:0] c,
  input  logic signed [DW-1:0] s,
  input  logic signed [DW-1:0] x,
  input  logic signed [DW-1:0] y,
  output logic signed [DW-1:0] nx,
  output logic signed [DW-1:0] ny
);

  localparam int FB = DW - 8;
  localparam int SW = 2 * DW + 1;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FB - 1);
  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (DW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic signed [2*DW-1:0] cx;
  logic signed [2*DW-1:0] sy;
  logic signed [2*DW-1:0] cy;
  logic signed [2*DW-1:0] sx;

  function automatic logic signed [DW-1:0] round_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] sh;
    t  = v + HALF;
    sh = t >>> FB;
    if (sh > SMAX) begin
      return SMAX[DW-1:0];
    end else if (sh < SMIN) begin
      return SMIN[DW-1:0];
    end
    return sh[DW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (load) begin
      cx <= c * x;
      sy <= s * y;
      cy <= c * y;
      sx <= s * x;
    end
  end

  assign nx = round_sat(SW'(cx) + SW'(sy));
  assign ny = round_sat(SW'(cy) - SW'(sx));

endmodule

FILE: sv/givens_qr_decomposition_core.sv
// ----------------------------------------------------------------------------
// givens_qr_decomposition_core
// Givens QR of a ROW_COUNT x COL_COUNT matrix held in one row cell per row.
// Load: one request per cycle, ROW_COUNT*COL_COUNT requests, then Q is
// seeded as the identity. Each rotation: a full circulation of two row cells,
// a root, two quotients (c and s) in the divider, a multiply and sum per
// rotated element. Output: R then Q, one element per cycle unless stalled.
// Reset (synchronous) empties the load count and sets the threshold to 17.
// ----------------------------------------------------------------------------
module givens_qr_decomposition_core import gqr_pkg::*; #(
  parameter int ROW_COUNT  = 4,
  parameter int COL_COUNT  = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic        [THR_W-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  element_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    which_matrix,
  output logic        [IDX_W-1:0] row_index,
  output logic        [IDX_W-1:0] col_index,
  output logic signed [OUT_W-1:0] out_value,
  output logic                    last
);

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = DW - 8;
  localparam int LEN = COL_COUNT + ROW_COUNT;
  localparam int RW  = $clog2(ROW_COUNT);
  localparam int CIW = $clog2(COL_COUNT + 1);
  localparam int PW  = $clog2(LEN + 1);
  localparam logic signed [DW-1:0] ONE = DW'(1) <<< FB;
  localparam logic signed [49:0] IN_MAX  = (50'sd1 <<< (DW - 1)) - 50'sd1;
  localparam logic signed [49:0] IN_MIN  = -IN_MAX - 50'sd1;
  localparam logic signed [49:0] OUT_MAX = (50'sd1 <<< (OUT_W - 1)) - 50'sd1;
  localparam logic signed [49:0] OUT_MIN = -OUT_MAX - 50'sd1;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_SEL,
    S_SEEK,
    S_CHECK,
    S_SQRT,
    S_DIVC,
    S_DIVS,
    S_WRJ,
    S_MUL,
    S_SUM,
    S_PASS,
    S_OUTR,
    S_OUTQ
  } state_t;

  state_t               state;
  logic [THR_W-1:0]     thr;
  logic [RW-1:0]        ld_row;
  logic [CIW-1:0]       ld_col;
  logic [RW-1:0]        k;
  logic [CIW-1:0]       j;
  logic [RW-1:0]        i;
  logic [PW-1:0]        p;
  logic [RW-1:0]        o_row;
  logic [CIW-1:0]       r_col;
  logic [RW-1:0]        q_col;
  logic signed [DW-1:0] m_r;
  logic signed [DW-1:0] c_r;
  logic signed [DW-1:0] s_r;
  logic                 sq_start;
  logic                 dv_start;
  logic signed [DW-1:0] dv_num;

  logic signed [DW-1:0] head [ROW_COUNT];
  logic signed [DW-1:0] cell_din [ROW_COUNT];
  logic                 cell_shift [ROW_COUNT];

  logic [RW-1:0]        ip;
  logic signed [DW-1:0] head_a;
  logic signed [DW-1:0] head_b;
  logic [DW-1:0]        mag_b;
  logic                 p_last;
  logic                 out_take;
  logic signed [49:0]   in_ext;
  logic signed [DW-1:0] in_sat;
  logic signed [DW-1:0] out_src;
  logic signed [49:0]   out_ext;
  logic signed [OUT_W-1:0] out_sat;

  unit_stat_t           sq_stat;
  unit_stat_t           dv_stat;
  logic [DW-1:0]        sq_root;
  logic signed [DW-1:0] dv_quo;
  logic signed [DW-1:0] rot_x;
  logic signed [DW-1:0] rot_y;

  genvar gr;
  generate
    for (gr = 0; gr < ROW_COUNT; gr++) begin : g_row
      gqr_row_cell #(
        .LEN (LEN),
        .DW  (DW)
      ) u_row (
        .clk   (clk),
        .shift (cell_shift[gr]),
        .din   (cell_din[gr]),
        .head  (head[gr])
      );
    end
  endgenerate

  gqr_sqrt #(.DW(DW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .a     (head_a),
    .b     (head_b),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  gqr_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (m_r),
    .stat  (dv_stat),
    .quo   (dv_quo)
  );

  gqr_rotate #(.DW(DW)) u_rot (
    .clk  (clk),
    .load (state == S_MUL),
    .c    (c_r),
    .s    (s_r),
    .x    (head_a),
    .y    (head_b),
    .nx   (rot_x),
    .ny   (rot_y)
  );

  always_comb begin
    ip       = i - 1'b1;
    head_a   = head[ip];
    head_b   = head[i];
    mag_b    = head_b[DW-1] ? DW'(-head_b) : DW'(head_b);
    p_last   = (p == PW'(LEN - 1));
    out_take = !out_valid || out_ready;
    in_ready = (state == S_LOAD);

    in_ext = 50'(element_value);
    if (in_ext > IN_MAX) begin
      in_sat = IN_MAX[DW-1:0];
    end else if (in_ext < IN_MIN) begin
      in_sat = IN_MIN[DW-1:0];
    end else begin
      in_sat = in_ext[DW-1:0];
    end

    out_src = (state == S_OUTQ) ? head[q_col] : head[o_row];
    out_ext = 50'(out_src);
    if (out_ext > OUT_MAX) begin
      out_sat = OUT_MAX[OUT_W-1:0];
    end else if (out_ext < OUT_MIN) begin
      out_sat = OUT_MIN[OUT_W-1:0];
    end else begin
      out_sat = out_ext[OUT_W-1:0];
    end
  end

  always_comb begin
    for (int r = 0; r < ROW_COUNT; r++) begin
      cell_shift[r] = 1'b0;
      cell_din[r]   = head[r];
    end
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cell_shift[ld_row] = 1'b1;
          cell_din[ld_row]   = in_sat;
        end
      end
      S_INIT: begin
        for (int r = 0; r < ROW_COUNT; r++) begin
          cell_shift[r] = 1'b1;
          cell_din[r]   = (k == RW'(r)) ? ONE : '0;
        end
      end
      S_SEEK: begin
        if (p != PW'(j)) begin
          cell_shift[ip] = 1'b1;
          cell_shift[i]  = 1'b1;
        end
      end
      S_PASS: begin
        cell_shift[ip] = 1'b1;
        cell_shift[i]  = 1'b1;
      end
      S_WRJ: begin
        cell_shift[ip] = 1'b1;
        cell_shift[i]  = 1'b1;
        cell_din[ip]   = m_r;
        cell_din[i]    = '0;
      end
      S_SUM: begin
        cell_shift[ip] = 1'b1;
        cell_shift[i]  = 1'b1;
        cell_din[ip]   = rot_x;
        cell_din[i]    = rot_y;
      end
      S_OUTR: begin
        if (out_take) begin
          cell_shift[o_row] = 1'b1;
        end
      end
      S_OUTQ: begin
        if (out_take && q_col == RW'(ROW_COUNT - 1)) begin
          for (int r = 0; r < ROW_COUNT; r++) begin
            cell_shift[r] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_write) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      ld_row    <= '0;
      ld_col    <= '0;
      out_valid <= 1'b0;
      sq_start  <= 1'b0;
      dv_start  <= 1'b0;
    end else begin
      sq_start <= (state == S_CHECK) && !(mag_b < thr);
      dv_start <= ((state == S_SQRT) && sq_stat.done && (sq_root != '0)) ||
                  ((state == S_DIVC) && dv_stat.done);
      if (out_ready && !(out_take && (state == S_OUTR || state == S_OUTQ))) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (ld_row == RW'(ROW_COUNT - 1)) begin
              ld_row <= '0;
              if (ld_col == CIW'(COL_COUNT - 1)) begin
                ld_col <= '0;
                k      <= '0;
                state  <= S_INIT;
              end else begin
                ld_col <= ld_col + 1'b1;
              end
            end else begin
              ld_row <= ld_row + 1'b1;
            end
          end
        end
        S_INIT: begin
          k <= k + 1'b1;
          if (k == RW'(ROW_COUNT - 1)) begin
            j     <= '0;
            i     <= RW'(ROW_COUNT - 1);
            state <= S_SEL;
          end
        end
        S_SEL: begin
          if (j == CIW'(COL_COUNT)) begin
            o_row <= '0;
            r_col <= '0;
            state <= S_OUTR;
          end else if (i > j) begin
            p     <= '0;
            state <= S_SEEK;
          end else begin
            j <= j + 1'b1;
            i <= RW'(ROW_COUNT - 1);
          end
        end
        S_SEEK: begin
          if (p == PW'(j)) begin
            state <= S_CHECK;
          end else begin
            p <= p + 1'b1;
          end
        end
        S_CHECK: begin
          if (mag_b < thr) begin
            state <= S_PASS;
          end else begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_stat.done) begin
            if (sq_root == '0) begin
              state <= S_PASS;
            end else begin
              m_r    <= $signed(sq_root);
              dv_num <= head_a;
              state  <= S_DIVC;
            end
          end
        end
        S_DIVC: begin
          if (dv_stat.done) begin
            c_r    <= dv_quo;
            dv_num <= head_b;
            state  <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (dv_stat.done) begin
            s_r   <= dv_quo;
            state <= S_WRJ;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_WRJ, S_SUM, S_PASS: begin
          p <= p + 1'b1;
          if (p_last) begin
            if (ip > j) begin
              i <= ip;
            end else begin
              j <= j + 1'b1;
              i <= RW'(ROW_COUNT - 1);
            end
            state <= S_SEL;
          end else if (state != S_PASS) begin
            state <= S_MUL;
          end
        end
        S_OUTR: begin
          if (out_take) begin
            out_valid    <= 1'b1;
            which_matrix <= MAT_R;
            row_index    <= IDX_W'(o_row);
            col_index    <= IDX_W'(r_col);
            out_value    <= out_sat;
            last         <= 1'b0;
            if (r_col == CIW'(COL_COUNT - 1)) begin
              r_col <= '0;
              if (o_row == RW'(ROW_COUNT - 1)) begin
                o_row <= '0;
                q_col <= '0;
                state <= S_OUTQ;
              end else begin
                o_row <= o_row + 1'b1;
              end
            end else begin
              r_col <= r_col + 1'b1;
            end
          end
        end
        S_OUTQ: begin
          if (out_take) begin
            out_valid    <= 1'b1;
            which_matrix <= MAT_Q;
            row_index    <= IDX_W'(o_row);
            col_index    <= IDX_W'(q_col);
            out_value    <= out_sat;
            last         <= (o_row == RW'(ROW_COUNT - 1)) && (q_col == RW'(ROW_COUNT - 1));
            if (q_col == RW'(ROW_COUNT - 1)) begin
              q_col <= '0;
              if (o_row == RW'(ROW_COUNT - 1)) begin
                o_row <= '0;
                state <= S_LOAD;
              end else begin
                o_row <= o_row + 1'b1;
              end
            end else begin
              q_col <= q_col + 1'b1;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTH
  a_last_is_q: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> which_matrix == MAT_Q)
    else $error("last flag on an R element");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(sq_stat.busy && dv_stat.busy))
    else $error("root and divide units busy together");

  a_no_load_during_r: assert property (@(posedge clk) disable iff (rst)
    out_valid && which_matrix == MAT_R |-> !in_ready)
    else $error("input taken while R is draining");

  a_div_after_root: assert property (@(posedge clk) disable iff (rst)
    $rose(dv_stat.busy) |-> $past(sq_stat.done, 2) || $past(dv_stat.done, 2))
    else $error("divide started out of sequence");
`endif

endmodule
